[design/umcs_pkg.sv]
// ----------------------------------------------------------------------------
// umcs_pkg
// Shared types and constants for the unquoted metacharacter scanner.
// ----------------------------------------------------------------------------
package umcs_pkg;

   localparam int CHAR_W  = 8;
   localparam int TDATA_W = 8;

   typedef struct packed {
      logic in_single_quote;
      logic in_double_quote;
      logic escape_pending;
      logic at_word_start;
      logic assign_name_ok;
      logic hit_seen;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      in_single_quote: 1'b0,
      in_double_quote: 1'b0,
      escape_pending:  1'b0,
      at_word_start:   1'b1,
      assign_name_ok:  1'b0,
      hit_seen:        1'b0
   };

endpackage

[design/umcs_scan_step.sv]
// ----------------------------------------------------------------------------
// umcs_scan_step
// Next-state logic for one command-line byte: quote, escape, word and
// assignment-name tracking plus the sticky restricted-symbol flag.
// ----------------------------------------------------------------------------
module umcs_scan_step (
   input  logic [umcs_pkg::CHAR_W-1:0] ch,
   input  umcs_pkg::scan_state_type    cur_state,
   output umcs_pkg::scan_state_type    nxt_state
);

   localparam logic [umcs_pkg::CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_SQUOTE    = 8'h27;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_EQUAL     = 8'h3D;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_AT        = 8'h40;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_DOT       = 8'h2E;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_CR        = 8'h0D;

   logic is_space;
   logic is_letter;
   logic is_digit;
   logic is_restricted;
   logic is_name_first;
   logic is_name_rest;

   assign is_space  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
   assign is_letter = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
   assign is_digit  = (ch >= 8'h30 && ch <= 8'h39);
   assign is_restricted = (ch == 8'h3B) || (ch == 8'h3C) || (ch == 8'h3E) ||
                          (ch == 8'h7C) || (ch == 8'h28) || (ch == 8'h29) ||
                          (ch == 8'h2A) || (ch == 8'h26) || (ch == 8'h24);
   assign is_name_first = is_letter || (ch == CH_UNDERSCORE) || (ch == CH_AT);
   assign is_name_rest  = is_name_first || is_digit || (ch == CH_DOT);

   always_comb begin
      nxt_state = cur_state;
      priority if (cur_state.escape_pending) begin
         nxt_state.escape_pending = 1'b0;
         nxt_state.at_word_start  = 1'b0;
         nxt_state.assign_name_ok = 1'b0;
      end else if (ch == CH_BACKSLASH) begin
         nxt_state.escape_pending = 1'b1;
         nxt_state.at_word_start  = 1'b0;
         nxt_state.assign_name_ok = 1'b0;
      end else if (cur_state.in_single_quote) begin
         if (ch == CH_SQUOTE) begin
            nxt_state.in_single_quote = 1'b0;
         end
      end else if (cur_state.in_double_quote) begin
         if (ch == CH_DQUOTE) begin
            nxt_state.in_double_quote = 1'b0;
         end
      end else if (ch == CH_SQUOTE) begin
         nxt_state.in_single_quote = 1'b1;
         nxt_state.at_word_start   = 1'b0;
         nxt_state.assign_name_ok  = 1'b0;
      end else if (ch == CH_DQUOTE) begin
         nxt_state.in_double_quote = 1'b1;
         nxt_state.at_word_start   = 1'b0;
         nxt_state.assign_name_ok  = 1'b0;
      end else if (is_space) begin
         nxt_state.at_word_start  = 1'b1;
         nxt_state.assign_name_ok = 1'b0;
      end else if (is_restricted) begin
         nxt_state.hit_seen = 1'b1;
      end else if (ch == CH_EQUAL) begin
         if (!cur_state.assign_name_ok) begin
            nxt_state.hit_seen = 1'b1;
         end
         nxt_state.assign_name_ok = 1'b0;
      end else if (cur_state.at_word_start) begin
         nxt_state.assign_name_ok = is_name_first;
         nxt_state.at_word_start  = 1'b0;
      end else begin
         if (!is_name_rest) begin
            nxt_state.assign_name_ok = 1'b0;
         end
      end
   end

endmodule

[design/unquoted_metachar_scanner_core.sv]
// ----------------------------------------------------------------------------
// unquoted_metachar_scanner_core
// Byte-stream scanner that flags unquoted shell metacharacters per line.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel carries one command-line byte per transaction in
//   req_tdata; a transaction with req_tlast high is the end of line and its
//   byte is ignored. Each end of line produces exactly one response
//   transaction whose rsp_tdata bit 0 is 1 when an unquoted restricted
//   symbol or an invalid '=' was seen; bytes produce no response.
//   Throughput is one transaction per cycle unless an end of line is held
//   back as described below: a byte register feeds the scan logic, which
//   updates the scan state, or on an end of line loads the response register.
//   When the receiver stalls, the response is held; bytes keep flowing, and
//   only a second end of line waits in the byte register until the pending
//   response is taken, which then backpressures req_tready.
//   Synchronous reset empties both registers and returns the scan state to
//   word start with no quotes, no escape and no hit.
// ----------------------------------------------------------------------------
module unquoted_metachar_scanner_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [umcs_pkg::TDATA_W-1:0]        req_tdata,  // [7:0] ch
   input  logic                                req_tlast,  // end_of_line
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [umcs_pkg::TDATA_W-1:0]        rsp_tdata   // [0] restricted_found
);

   logic                             in_valid_ff;
   logic                             in_valid_in;
   logic [umcs_pkg::CHAR_W-1:0]      in_ch_ff;
   logic                             in_last_ff;
   umcs_pkg::scan_state_type         state_ff;
   umcs_pkg::scan_state_type         state_in;
   umcs_pkg::scan_state_type         step_state;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             rsp_found_ff;
   logic                             rsp_found_in;
   logic                             out_free;
   logic                             in_advance;
   logic                             req_take;

   umcs_scan_step u_step (
      .ch        (in_ch_ff),
      .cur_state (state_ff),
      .nxt_state (step_state)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_advance = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || in_advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !in_advance);
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      if (in_advance) begin
         if (in_last_ff) begin
            state_in     = umcs_pkg::SCAN_STATE_RESET;
            rsp_valid_in = 1'b1;
            rsp_found_in = state_ff.hit_seen;
         end else begin
            state_in = step_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= umcs_pkg::SCAN_STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ch_ff   <= req_tdata[umcs_pkg::CHAR_W-1:0];
         in_last_ff <= req_tlast;
      end
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(umcs_pkg::TDATA_W-1){1'b0}}, rsp_found_ff};

endmodule

[design/umcs_checker.sv]
// ----------------------------------------------------------------------------
// umcs_checker
// Port-level checks for the unquoted metacharacter scanner, bound to the core.
// ----------------------------------------------------------------------------
module umcs_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic [umcs_pkg::TDATA_W-1:0] req_tdata,
   input logic                         req_tlast,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [umcs_pkg::TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_rsp_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[umcs_pkg::TDATA_W-1:1] == '0)
      else $error("response padding bits not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_from_eol: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("response without end-of-line two cycles earlier");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=>
         req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("request changed while stalled");

endmodule

bind unquoted_metachar_scanner_core umcs_checker u_umcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/unquoted_metachar_scanner_core_tb.sv]
// ----------------------------------------------------------------------------
// unquoted_metachar_scanner_core_tb
// Streams command lines, one byte per transaction, into the scanner and
// checks each end-of-line verdict. A directed table covers empty lines,
// escapes, quotes, assignment names and byte extremes. Random lines follow,
// with idle and stall bursts on both channels. Directed verdicts come from
// the table; the rest are compared with an in-testbench scan-state predictor.
// ----------------------------------------------------------------------------
module unquoted_metachar_scanner_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ITEMS     = 1350;
   localparam int CALM_ITEMS    = 200;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int NUM_ROWS      = 25;

   localparam logic [umcs_pkg::CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_EQUALS = 8'h3D;
   localparam logic [umcs_pkg::CHAR_W-1:0] CH_TAB    = 8'h09;

   typedef struct packed {
      logic [umcs_pkg::CHAR_W-1:0] ch;
      logic                        eol;
      logic                        typed;
      logic                        verdict;
   } line_row_type;

   localparam line_row_type LINE_ROWS [NUM_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{";", 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1, 1'b1},
      '{"_", 1'b0, 1'b0, 1'b0}, '{CH_EQUALS, 1'b0, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 1'b0},
      '{8'hFF, 1'b0, 1'b0, 1'b0}, '{CH_EQUALS, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b1},
      '{CH_BSLASH, 1'b0, 1'b0, 1'b0}, '{"$", 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0}, '{"|", 1'b0, 1'b0, 1'b0},
      '{CH_SQUOTE, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1, 1'b0},
      '{CH_DQUOTE, 1'b0, 1'b0, 1'b0}, '{CH_BSLASH, 1'b0, 1'b0, 1'b0},
      '{CH_DQUOTE, 1'b0, 1'b0, 1'b0}, '{"&", 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{"@", 1'b0, 1'b0, 1'b0}, '{CH_TAB, 1'b0, 1'b0, 1'b0},
      '{CH_EQUALS, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b1, 1'b1}
   };

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [umcs_pkg::TDATA_W-1:0] req_tdata  = '0;  // [7:0] ch
   logic                         req_tlast  = 1'b0; // end_of_line
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [umcs_pkg::TDATA_W-1:0] rsp_tdata;         // [0] restricted_found

   umcs_pkg::scan_state_type scan_st = umcs_pkg::SCAN_STATE_RESET;
   bit             verdict_queue [$];
   int             mismatches  = 0;
   int             items_sent  = 0;
   int             cycle_count = 0;
   bit             calm        = 1'b0;

   unquoted_metachar_scanner_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic bit is_letter(input logic [umcs_pkg::CHAR_W-1:0] c);
      return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
   endfunction

   function automatic bit is_digit(input logic [umcs_pkg::CHAR_W-1:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic void scan_byte(input logic [umcs_pkg::CHAR_W-1:0] c);
      if (scan_st.escape_pending || c == CH_BSLASH) begin
         scan_st.escape_pending = !scan_st.escape_pending;
         scan_st.at_word_start  = 1'b0;
         scan_st.assign_name_ok = 1'b0;
         return;
      end
      if (scan_st.in_single_quote) begin
         if (c == CH_SQUOTE) scan_st.in_single_quote = 1'b0;
         return;
      end
      if (scan_st.in_double_quote) begin
         if (c == CH_DQUOTE) scan_st.in_double_quote = 1'b0;
         return;
      end
      if (c == CH_SQUOTE || c == CH_DQUOTE) begin
         if (c == CH_SQUOTE) scan_st.in_single_quote = 1'b1;
         else scan_st.in_double_quote = 1'b1;
         scan_st.at_word_start  = 1'b0;
         scan_st.assign_name_ok = 1'b0;
         return;
      end
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
         scan_st.at_word_start  = 1'b1;
         scan_st.assign_name_ok = 1'b0;
         return;
      end
      if (c == ";" || c == "<" || c == ">" || c == "|" || c == "(" ||
          c == ")" || c == "*" || c == "&" || c == "$") begin
         scan_st.hit_seen = 1'b1;
         return;
      end
      if (c == CH_EQUALS) begin
         if (!scan_st.assign_name_ok) scan_st.hit_seen = 1'b1;
         scan_st.assign_name_ok = 1'b0;
         return;
      end
      if (scan_st.at_word_start) begin
         scan_st.assign_name_ok = is_letter(c) || c == "_" || c == "@";
         scan_st.at_word_start  = 1'b0;
      end else if (!(is_letter(c) || is_digit(c) || c == "_" || c == "." || c == "@")) begin
         scan_st.assign_name_ok = 1'b0;
      end
   endfunction

   function automatic logic [umcs_pkg::CHAR_W-1:0] pick_line_byte();
      int          r;
      logic [umcs_pkg::CHAR_W-1:0] name_chars [8];
      string       restricted_chars;
      r = $urandom_range(0, 99);
      name_chars = '{"a", "Z", "q", "_", "@", ".", "7", "0"};
      restricted_chars = ";<>|()*&$";
      if (r < 36) return name_chars[$urandom_range(0, 7)];
      if (r < 46) return CH_EQUALS;
      if (r < 58) return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : " ";
      if (r < 66) return ($urandom_range(0, 1) == 0) ? CH_SQUOTE : CH_DQUOTE;
      if (r < 71) return CH_BSLASH;
      if (r < 75) return restricted_chars[$urandom_range(0, 8)];
      if (r < 88) return 8'($urandom_range(65, 122));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic send_item(input logic [umcs_pkg::CHAR_W-1:0] c, input bit eol,
                            input bit typed, input bit typed_verdict);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      if (eol) begin
         verdict_queue.push_back(typed ? typed_verdict : scan_st.hit_seen);
         scan_st = umcs_pkg::SCAN_STATE_RESET;
      end else begin
         scan_byte(c);
      end
      items_sent++;
      calm = items_sent >= NUM_ITEMS - CALM_ITEMS;
   endtask

   task automatic wait_drained();
      while (verdict_queue.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected response, restricted_found",
                            int'(rsp_tdata[0]), 0);
         end else begin
            if (rsp_tdata[0] !== verdict_queue[0])
               report_mismatch("restricted_found", int'(rsp_tdata[0]),
                               int'(verdict_queue[0]));
            if (rsp_tdata[umcs_pkg::TDATA_W-1:1] !== '0)
               report_mismatch("rsp_tdata padding",
                               int'(rsp_tdata[umcs_pkg::TDATA_W-1:1]), 0);
            void'(verdict_queue.pop_front());
         end
      end
   end

   initial begin
      int run;
      repeat (10) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
         repeat (run) @(posedge clock);
         if (!calm) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      int line_no;
      int len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (LINE_ROWS[i])
         send_item(LINE_ROWS[i].ch, LINE_ROWS[i].eol, LINE_ROWS[i].typed, LINE_ROWS[i].verdict);
      line_no = 0;
      while (items_sent < NUM_ITEMS) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
         repeat (len) send_item(pick_line_byte(), 1'b0, 1'b0, 1'b0);
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0);
         line_no++;
         if (line_no == 40 || line_no == 120) begin
            // hold the sender until every verdict is back
            req_tvalid <= 1'b0;
            wait_drained();
         end
      end
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[sim.f]
design/umcs_pkg.sv
design/umcs_scan_step.sv
design/unquoted_metachar_scanner_core.sv
design/umcs_checker.sv
dv/unquoted_metachar_scanner_core_tb.sv
